[rtl/core/assert_macros.svh]
// Concurrent assertion helpers, clocked on clk_i and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(name, ante, cons, msg)
`define ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

[rtl/core/qga_pkg.sv]
`default_nettype none

package qga_pkg;

  localparam int NUM_QUBITS_DEF = 8;

  localparam logic signed [15:0] Q15_ONE = 16'sh7FFF;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_GATE  = 2'd2,
    KIND_CLEAR = 2'd3
  } qga_kind_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_GATE,
    S_CLEAR,
    S_DONE
  } qga_state_e;

  // Gate register indexes
  localparam logic [2:0] REG_A_RE = 3'd0;
  localparam logic [2:0] REG_A_IM = 3'd1;
  localparam logic [2:0] REG_B_RE = 3'd2;
  localparam logic [2:0] REG_B_IM = 3'd3;
  localparam logic [2:0] REG_C_RE = 3'd4;
  localparam logic [2:0] REG_C_IM = 3'd5;
  localparam logic [2:0] REG_D_RE = 3'd6;
  localparam logic [2:0] REG_D_IM = 3'd7;

  localparam int NUM_REGS = 8;

  localparam logic signed [15:0] GATE_RESET [NUM_REGS] = '{
    Q15_ONE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, Q15_ONE, 16'sd0
  };

  // Phases of one amplitude pair
  localparam logic [3:0] PH_RD_X  = 4'd0;
  localparam logic [3:0] PH_RD_Y  = 4'd1;
  localparam logic [3:0] PH_MUL0  = 4'd2;
  localparam logic [3:0] PH_SUM_X = 4'd5;
  localparam logic [3:0] PH_WR_X  = 4'd6;
  localparam logic [3:0] PH_SUM_Y = 4'd7;
  localparam logic [3:0] PH_WR_Y  = 4'd8;

  // Complex products in issue order
  localparam logic [1:0] TERM_AX = 2'd0;
  localparam logic [1:0] TERM_BY = 2'd1;
  localparam logic [1:0] TERM_CX = 2'd2;
  localparam logic [1:0] TERM_DY = 2'd3;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/qubit_gate_apply.sv]
// State-vector engine for single-qubit gates on 2^NUM_QUBITS Q15 complex amplitudes.
// Input channel (in_valid_i / in_stall_o) carries one command per beat: load an
// amplitude, read one back, apply the 2x2 gate held in the gate registers to
// target_qubit_i, or clear the vector to the ground state. Every command returns
// exactly one beat on the output channel (out_valid_o / out_stall_i).
// Gate registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must
// write them only while idle; the block itself does not enforce this.
// From accept: load, bad index or bad target go straight to the done state; read
// first takes one registered memory read; clear writes one entry per cycle over all
// 2^NUM_QUBITS entries; gate reads each of the 2^(NUM_QUBITS-1) pairs twice and
// writes it twice through the amplitude RAM (one read port, one write port), and
// its four complex products go one per cycle through a shared four-multiplier
// complex unit. The done state then loads the output register once it is free.
// One command is in flight at a time; in_stall_o is low only when idle.
// After reset the block sweeps all 2^NUM_QUBITS RAM entries to the ground state
// with in_stall_o high. A finished result waits in the output register while the
// receiver stalls; the next result is held until that beat is taken.

`default_nettype none

`include "assert_macros.svh"

module qubit_gate_apply #(
  parameter int NUM_QUBITS = qga_pkg::NUM_QUBITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic signed [15:0] cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic [7:0]         amp_index_i,
  input  wire logic signed [15:0] load_re_i,
  input  wire logic signed [15:0] load_im_i,
  input  wire logic [2:0]         target_qubit_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [15:0] read_re_o,
  output      logic signed [15:0] read_im_o,
  output      logic               bad_target_o
);
  import qga_pkg::*;

  localparam int AW        = NUM_QUBITS;
  localparam int AMP_COUNT = 1 << NUM_QUBITS;
  localparam logic [AW-1:0] ADDR_LAST = AW'(AMP_COUNT - 1);
  localparam logic [AW-1:0] PAIR_LAST = AW'(AMP_COUNT / 2 - 1);

  qga_state_e state_q, state_d;
  logic [3:0]    ph_q, ph_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic signed [15:0] gate_q [NUM_REGS];

  logic [2:0]         tgt_q, tgt_d;
  logic signed [15:0] res_re_q, res_re_d, res_im_q, res_im_d;
  logic               res_bad_q, res_bad_d;
  logic [31:0]        x_q, x_d, y_q, y_d;
  logic signed [15:0] new_x_re_q, new_x_re_d, new_x_im_q, new_x_im_d;
  logic signed [15:0] new_y_re_q, new_y_re_d, new_y_im_q, new_y_im_d;
  logic signed [16:0] prod_q [4];
  logic signed [16:0] prod_d [4];
  logic signed [15:0] cplx_re_q, cplx_re_d, cplx_im_q, cplx_im_d;
  logic signed [15:0] acc_re_q, acc_im_q;
  logic signed [15:0] out_re_q, out_re_d, out_im_q, out_im_d;
  logic               out_bad_q, out_bad_d;

  logic [31:0]   mem [AMP_COUNT];
  logic [31:0]   rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0]   mem_wd;

  logic [AW-1:0] low_mask, pair_n, pair_m, in_addr;
  logic          idx_ok, tgt_ok;
  logic [1:0]    term;
  logic signed [15:0] coef_re, coef_im, dat_re, dat_im;
  logic signed [31:0] mul_rr, mul_ii, mul_ri, mul_ir;
  logic signed [15:0] sum_re, sum_im;

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign read_re_o    = out_re_q;
  assign read_im_o    = out_im_q;
  assign bad_target_o = out_bad_q;

  assign in_addr = AW'(amp_index_i);
  assign idx_ok  = (32'(amp_index_i) < AMP_COUNT);
  assign tgt_ok  = (32'(target_qubit_i) < NUM_QUBITS);

  // Insert a zero at the target bit of the pair count to get the lower address.
  assign low_mask = AW'((AW'(1) << tgt_q) - AW'(1));
  assign pair_n   = AW'(((cnt_q & ~low_mask) << 1) | (cnt_q & low_mask));
  assign pair_m   = pair_n | AW'(AW'(1) << tgt_q);

  // Shared complex multiply: one gate entry times one amplitude per cycle.
  assign term = 2'(ph_q - PH_MUL0);

  always_comb begin
    case (term)
      TERM_AX: begin
        coef_re = gate_q[REG_A_RE];
        coef_im = gate_q[REG_A_IM];
      end
      TERM_BY: begin
        coef_re = gate_q[REG_B_RE];
        coef_im = gate_q[REG_B_IM];
      end
      TERM_CX: begin
        coef_re = gate_q[REG_C_RE];
        coef_im = gate_q[REG_C_IM];
      end
      TERM_DY: begin
        coef_re = gate_q[REG_D_RE];
        coef_im = gate_q[REG_D_IM];
      end
      default: begin
        coef_re = gate_q[REG_A_RE];
        coef_im = gate_q[REG_A_IM];
      end
    endcase
    dat_re = term[0] ? y_q[31:16] : x_q[31:16];
    dat_im = term[0] ? y_q[15:0]  : x_q[15:0];
    mul_rr = coef_re * dat_re;
    mul_ii = coef_im * dat_im;
    mul_ri = coef_re * dat_im;
    mul_ir = coef_im * dat_re;
    // Arithmetic shift right by 15 rounds toward minus infinity.
    prod_d[0] = mul_rr[31:15];
    prod_d[1] = mul_ii[31:15];
    prod_d[2] = mul_ri[31:15];
    prod_d[3] = mul_ir[31:15];
    cplx_re_d = sat16(18'(prod_q[0]) - 18'(prod_q[1]));
    cplx_im_d = sat16(18'(prod_q[2]) + 18'(prod_q[3]));
    sum_re    = sat16(18'(acc_re_q) + 18'(cplx_re_q));
    sum_im    = sat16(18'(acc_im_q) + 18'(cplx_im_q));
  end

  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    cnt_d       = cnt_q;
    tgt_d       = tgt_q;
    res_re_d    = res_re_q;
    res_im_d    = res_im_q;
    res_bad_d   = res_bad_q;
    x_d         = x_q;
    y_d         = y_q;
    new_x_re_d  = new_x_re_q;
    new_x_im_d  = new_x_im_q;
    new_y_re_d  = new_y_re_q;
    new_y_im_d  = new_y_im_q;
    out_re_d    = out_re_q;
    out_im_d    = out_im_q;
    out_bad_d   = out_bad_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_wa      = cnt_q;
    mem_wd      = '0;
    mem_ra      = pair_n;

    // Drop the beat once taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt_q;
        mem_wd = (cnt_q == '0) ? {Q15_ONE, 16'h0000} : '0;
        if (cnt_q == ADDR_LAST) begin
          cnt_d   = '0;
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_re_d  = '0;
          res_im_d  = '0;
          res_bad_d = 1'b0;
          state_d   = S_DONE;
          case (qga_kind_e'(kind_i))
            KIND_LOAD: begin
              if (idx_ok) begin
                mem_we = 1'b1;
                mem_wa = in_addr;
                mem_wd = {load_re_i, load_im_i};
              end else begin
                res_bad_d = 1'b1;
              end
            end
            KIND_READ: begin
              mem_ra = in_addr;
              if (idx_ok) begin
                state_d = S_READ;
              end else begin
                res_bad_d = 1'b1;
              end
            end
            KIND_GATE: begin
              tgt_d = target_qubit_i;
              if (tgt_ok) begin
                cnt_d   = '0;
                ph_d    = PH_RD_X;
                state_d = S_GATE;
              end else begin
                res_bad_d = 1'b1;
              end
            end
            KIND_CLEAR: begin
              cnt_d   = '0;
              state_d = S_CLEAR;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        res_re_d = rdata_q[31:16];
        res_im_d = rdata_q[15:0];
        state_d  = S_DONE;
      end
      S_GATE: begin
        ph_d = ph_q + 4'd1;
        if (ph_q == PH_RD_Y) begin
          mem_ra = pair_m;
          x_d    = rdata_q;
        end
        if (ph_q == PH_MUL0) begin
          y_d = rdata_q;
        end
        if (ph_q == PH_SUM_X) begin
          new_x_re_d = sum_re;
          new_x_im_d = sum_im;
        end
        if (ph_q == PH_SUM_Y) begin
          new_y_re_d = sum_re;
          new_y_im_d = sum_im;
        end
        if (ph_q == PH_WR_X) begin
          mem_we = 1'b1;
          mem_wa = pair_n;
          mem_wd = {new_x_re_q, new_x_im_q};
        end
        if (ph_q == PH_WR_Y) begin
          mem_we = 1'b1;
          mem_wa = pair_m;
          mem_wd = {new_y_re_q, new_y_im_q};
          ph_d   = PH_RD_X;
          if (cnt_q == PAIR_LAST) begin
            cnt_d   = '0;
            state_d = S_DONE;
          end else begin
            cnt_d = cnt_q + AW'(1);
          end
        end
      end
      S_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_re_d    = res_re_q;
          out_im_d    = res_im_q;
          out_bad_d   = res_bad_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ph_q        <= PH_RD_X;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        gate_q[i] <= GATE_RESET[i];
      end
    end else if (cfg_we_i) begin
      gate_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q      <= tgt_d;
    res_re_q   <= res_re_d;
    res_im_q   <= res_im_d;
    res_bad_q  <= res_bad_d;
    x_q        <= x_d;
    y_q        <= y_d;
    new_x_re_q <= new_x_re_d;
    new_x_im_q <= new_x_im_d;
    new_y_re_q <= new_y_re_d;
    new_y_im_q <= new_y_im_d;
    for (int i = 0; i < 4; i++) begin
      prod_q[i] <= prod_d[i];
    end
    cplx_re_q  <= cplx_re_d;
    cplx_im_q  <= cplx_im_d;
    // Delay one product so the pair sum sees the previous term.
    acc_re_q   <= cplx_re_q;
    acc_im_q   <= cplx_im_q;
    out_re_q   <= out_re_d;
    out_im_q   <= out_im_d;
    out_bad_q  <= out_bad_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  `ASSERT_IMPL(a_out_from_done, $rose(out_valid_q), $past(state_q == S_DONE), "output beat without a finished command")
  `ASSERT_NEXT(a_bad_gate_no_sweep, in_valid_i && !in_stall_o && kind_i == KIND_GATE && !tgt_ok, state_q == S_DONE, "out of range gate started a sweep")
  `ASSERT_IMPL(a_gate_phase_range, state_q == S_GATE, ph_q <= PH_WR_Y, "pair phase out of range")

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import qga_pkg::*;

  localparam int AMP_N = 1 << NUM_QUBITS_DEF;
  localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               bad;
  } amp_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_idx = 3'd0;
  logic signed [15:0] cfg_data = 16'sd0;
  logic               in_valid = 1'b0;
  qga_kind_e          cmd_kind = KIND_READ;
  logic [7:0]         amp_index = 8'd0;
  logic signed [15:0] load_re = 16'sd0;
  logic signed [15:0] load_im = 16'sd0;
  logic [2:0]         target_qubit = 3'd0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic signed [15:0] read_re;
  logic signed [15:0] read_im;
  logic               bad_target;

  qubit_gate_apply dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (cmd_kind),
    .amp_index_i    (amp_index),
    .load_re_i      (load_re),
    .load_im_i      (load_im),
    .target_qubit_i (target_qubit),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .read_re_o      (read_re),
    .read_im_o      (read_im),
    .bad_target_o   (bad_target)
  );

  always #2 clk = ~clk;

  // Shadow of the state vector and the gate registers
  logic signed [15:0] amp_re_m [AMP_N];
  logic signed [15:0] amp_im_m [AMP_N];
  logic signed [15:0] gate_m [NUM_REGS];
  amp_result_t        pending_results [$];

  int unsigned       n_err = 0;
  int unsigned       n_checked = 0;
  int unsigned       n_kind [4] = '{0, 0, 0, 0};
  int unsigned       n_settings = 0;
  longint unsigned   cycle_count = 0;
  int unsigned       stall_pct = 0;
  int unsigned       stall_left = 0;
  logic              gap_on = 1'b0;
  int unsigned       burst_left = 0;

  function automatic logic signed [15:0] clamp_q15(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Full product, arithmetic shift floors toward minus infinity
  function automatic longint q15_mul(input logic signed [15:0] x, input logic signed [15:0] y);
    longint p;
    p = longint'(x) * longint'(y);
    return p >>> 15;
  endfunction

  // One output row of the gate: row[0]*x + row[1]*y, each part saturated
  function automatic void gate_row(input int r,
                                   input logic signed [15:0] xr, input logic signed [15:0] xi,
                                   input logic signed [15:0] yr, input logic signed [15:0] yi,
                                   output logic signed [15:0] outr,
                                   output logic signed [15:0] outi);
    logic signed [15:0] ar, ai, br, bi;
    ar = clamp_q15(q15_mul(gate_m[r], xr) - q15_mul(gate_m[r + 1], xi));
    ai = clamp_q15(q15_mul(gate_m[r], xi) + q15_mul(gate_m[r + 1], xr));
    br = clamp_q15(q15_mul(gate_m[r + 2], yr) - q15_mul(gate_m[r + 3], yi));
    bi = clamp_q15(q15_mul(gate_m[r + 2], yi) + q15_mul(gate_m[r + 3], yr));
    outr = clamp_q15(longint'(ar) + longint'(br));
    outi = clamp_q15(longint'(ai) + longint'(bi));
  endfunction

  function automatic void ground_state();
    for (int i = 0; i < AMP_N; i++) begin
      amp_re_m[i] = 16'sd0;
      amp_im_m[i] = 16'sd0;
    end
    amp_re_m[0] = Q15_ONE;
  endfunction

  function automatic amp_result_t predict_cmd(input qga_kind_e k, input logic [7:0] idx,
                                              input logic signed [15:0] lre,
                                              input logic signed [15:0] lim,
                                              input logic [2:0] tq);
    amp_result_t r;
    int stride;
    logic signed [15:0] nr0, ni0, nr1, ni1;
    r = '0;
    case (k)
      KIND_LOAD: begin
        if (int'(idx) < AMP_N) begin
          amp_re_m[idx] = lre;
          amp_im_m[idx] = lim;
        end else begin
          r.bad = 1'b1;
        end
      end
      KIND_READ: begin
        if (int'(idx) < AMP_N) begin
          r.re = amp_re_m[idx];
          r.im = amp_im_m[idx];
        end else begin
          r.bad = 1'b1;
        end
      end
      KIND_GATE: begin
        if (int'(tq) < NUM_QUBITS_DEF) begin
          stride = 1 << tq;
          for (int n = 0; n < AMP_N; n++) begin
            if ((n & stride) == 0) begin
              gate_row(int'(REG_A_RE), amp_re_m[n], amp_im_m[n],
                       amp_re_m[n + stride], amp_im_m[n + stride], nr0, ni0);
              gate_row(int'(REG_C_RE), amp_re_m[n], amp_im_m[n],
                       amp_re_m[n + stride], amp_im_m[n + stride], nr1, ni1);
              amp_re_m[n] = nr0;
              amp_im_m[n] = ni0;
              amp_re_m[n + stride] = nr1;
              amp_im_m[n + stride] = ni1;
            end
          end
        end else begin
          r.bad = 1'b1;
        end
      end
      default: ground_state();
    endcase
    n_kind[k]++;
    return r;
  endfunction

  function automatic logic [NUM_REGS-1:0][15:0] make_gate(
      input logic signed [15:0] ar, input logic signed [15:0] ai,
      input logic signed [15:0] br, input logic signed [15:0] bi,
      input logic signed [15:0] cr, input logic signed [15:0] ci,
      input logic signed [15:0] dr, input logic signed [15:0] di);
    logic [NUM_REGS-1:0][15:0] g;
    g[REG_A_RE] = ar;
    g[REG_A_IM] = ai;
    g[REG_B_RE] = br;
    g[REG_B_IM] = bi;
    g[REG_C_RE] = cr;
    g[REG_C_IM] = ci;
    g[REG_D_RE] = dr;
    g[REG_D_IM] = di;
    return g;
  endfunction

  // Bias toward the rails and small values so both saturating and exact paths show up
  function automatic logic signed [15:0] rand_q15();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(600)) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_index();
    logic [7:0] v;
    v = 8'($urandom);
    // Keep half the traffic on a small hot set so reads see earlier loads
    if ($urandom_range(1) == 0) v[6:3] = {4{v[7]}};
    return v;
  endfunction

  task automatic send_cmd(input qga_kind_e k, input logic [7:0] idx,
                          input logic signed [15:0] lre, input logic signed [15:0] lim,
                          input logic [2:0] tq);
    in_valid <= 1'b1;
    cmd_kind <= k;
    amp_index <= idx;
    load_re <= lre;
    load_im <= lim;
    target_qubit <= tq;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_cmd(k, idx, lre, lim, tq));
    if (gap_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Hold the sender until every outstanding beat has been taken
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_gate(input logic [NUM_REGS-1:0][15:0] g);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= 3'(i);
      cfg_data <= g[i];
      @(posedge clk);
      gate_m[i] = g[i];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  task automatic note_mismatch(input string field, input int expv, input int actv);
    n_err++;
    if (n_err <= MAX_REPORTS)
      $display("%0t: %s expected %0d got %0d", $time, field, expv, actv);
  endtask

  always @(posedge clk) begin : check_results
    amp_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        n_err++;
        if (n_err <= MAX_REPORTS)
          $display("%0t: unexpected beat re=%0d im=%0d bad=%0b expected none",
                   $time, read_re, read_im, bad_target);
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (read_re !== exp_r.re) note_mismatch("read_re", exp_r.re, read_re);
        if (read_im !== exp_r.im) note_mismatch("read_im", exp_r.im, read_im);
        if (bad_target !== exp_r.bad) note_mismatch("bad_target", exp_r.bad, bad_target);
      end
    end
  end

  // Receiver stall pattern: runs of stall and free cycles
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_pct == 0) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(5);
    end else begin
      out_stall <= 1'b0;
      stall_left <= $urandom_range(7);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: timeout at cycle %0d with %0d beats outstanding",
               cycle_count, pending_results.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic test_reset_state();
    stall_pct = 30;
    gap_on = 1'b1;
    send_cmd(KIND_READ, 8'h00, 16'sd0, 16'sd0, 3'd0);
    send_cmd(KIND_READ, 8'hFF, 16'sd0, 16'sd0, 3'd0);
    // Reset gate is 32767 on the diagonal, so amplitudes shrink by one LSB
    send_cmd(KIND_GATE, 8'h00, 16'sd0, 16'sd0, 3'd0);
    send_cmd(KIND_READ, 8'h00, 16'sd0, 16'sd0, 3'd0);
    send_cmd(KIND_READ, 8'h01, 16'sd0, 16'sd0, 3'd0);
    wait_idle();
  endtask

  task automatic test_load_read();
    send_cmd(KIND_LOAD, 8'h00, 16'sh7FFF, 16'sh8000, 3'd0);
    send_cmd(KIND_LOAD, 8'hFF, 16'sh8000, 16'sh7FFF, 3'd7);
    send_cmd(KIND_LOAD, 8'hAA, 16'sh5555, 16'shAAAA, 3'd0);
    send_cmd(KIND_LOAD, 8'h55, 16'sd0, -16'sd1, 3'd0);
    send_cmd(KIND_READ, 8'hFF, 16'sd0, 16'sd0, 3'd0);
    send_cmd(KIND_READ, 8'h00, 16'sd0, 16'sd0, 3'd0);
    send_cmd(KIND_READ, 8'hAA, 16'sd0, 16'sd0, 3'd0);
    send_cmd(KIND_CLEAR, 8'h00, 16'sd0, 16'sd0, 3'd0);
    send_cmd(KIND_READ, 8'h00, 16'sd0, 16'sd0, 3'd0);
    send_cmd(KIND_READ, 8'hFF, 16'sd0, 16'sd0, 3'd0);
    wait_idle();
  endtask

  task automatic test_gate_ops();
    // Pauli X on the top qubit swaps amplitude 1 with 129
    program_gate(make_gate(16'sd0, 16'sd0, 16'sh7FFF, 16'sd0,
                           16'sh7FFF, 16'sd0, 16'sd0, 16'sd0));
    send_cmd(KIND_LOAD, 8'h01, 16'sd1000, -16'sd1000, 3'd0);
    send_cmd(KIND_GATE, 8'h00, 16'sd0, 16'sd0, 3'd7);
    send_cmd(KIND_READ, 8'h81, 16'sd0, 16'sd0, 3'd0);
    wait_idle();
    // Most negative entries everywhere drive the sums into saturation
    program_gate(make_gate(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                           16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    send_cmd(KIND_GATE, 8'h00, 16'sd0, 16'sd0, 3'd0);
    send_cmd(KIND_READ, 8'h00, 16'sd0, 16'sd0, 3'd0);
    send_cmd(KIND_READ, 8'h01, 16'sd0, 16'sd0, 3'd0);
    wait_idle();
    program_gate(make_gate(16'sd23170, 16'sd0, 16'sd23170, 16'sd0,
                           16'sd23170, 16'sd0, -16'sd23170, 16'sd0));
    send_cmd(KIND_CLEAR, 8'h00, 16'sd0, 16'sd0, 3'd0);
    send_cmd(KIND_GATE, 8'h00, 16'sd0, 16'sd0, 3'd3);
    send_cmd(KIND_READ, 8'h08, 16'sd0, 16'sd0, 3'd0);
    wait_idle();
  endtask

  task automatic run_mix(input int count, input logic [NUM_REGS-1:0][15:0] g,
                         input int unsigned stall_p, input logic gaps);
    int unsigned sel;
    program_gate(g);
    stall_pct = stall_p;
    gap_on = gaps;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_idle();
      sel = $urandom_range(99);
      if (sel < 46)
        send_cmd(KIND_LOAD, rand_index(), rand_q15(), rand_q15(), 3'($urandom));
      else if (sel < 88)
        send_cmd(KIND_READ, rand_index(), rand_q15(), rand_q15(), 3'($urandom));
      else if (sel < 96)
        send_cmd(KIND_GATE, rand_index(), rand_q15(), rand_q15(), 3'($urandom_range(7)));
      else
        send_cmd(KIND_CLEAR, rand_index(), rand_q15(), rand_q15(), 3'($urandom));
    end
    wait_idle();
  endtask

  task automatic test_random_mix();
    run_mix(205, make_gate(rand_q15(), rand_q15(), rand_q15(), rand_q15(),
                           rand_q15(), rand_q15(), rand_q15(), rand_q15()), 0, 1'b0);
    run_mix(205, make_gate(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                           16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF), 40, 1'b1);
    run_mix(205, make_gate(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                           16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000), 20, 1'b1);
    run_mix(205, make_gate(16'sd23170, 16'sd0, 16'sd23170, 16'sd0,
                           16'sd0, 16'sd23170, 16'sd0, -16'sd23170), 60, 1'b0);
    run_mix(205, make_gate(GATE_RESET[REG_A_RE], GATE_RESET[REG_A_IM],
                           GATE_RESET[REG_B_RE], GATE_RESET[REG_B_IM],
                           GATE_RESET[REG_C_RE], GATE_RESET[REG_C_IM],
                           GATE_RESET[REG_D_RE], GATE_RESET[REG_D_IM]), 0, 1'b1);
    run_mix(205, make_gate(rand_q15(), rand_q15(), rand_q15(), rand_q15(),
                           rand_q15(), rand_q15(), rand_q15(), rand_q15()), 30, 1'b1);
  endtask

  initial begin
    ground_state();
    gate_m = GATE_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_load_read();
    test_gate_ops();
    test_random_mix();
    repeat (20) @(posedge clk);
    $display("tb: %0d beats checked: load %0d, read %0d, gate %0d, clear %0d",
             n_checked, n_kind[KIND_LOAD], n_kind[KIND_READ], n_kind[KIND_GATE],
             n_kind[KIND_CLEAR]);
    $display("tb: %0d gate settings incl. both rails, targets 0..7, mixed gaps and stalls",
             n_settings);
    if (n_err == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[qubit_gate_apply.f]
+incdir+rtl/core
rtl/core/qga_pkg.sv
rtl/core/qubit_gate_apply.sv
tb/tb.sv
